[rtl/jvpp_pkg.sv]
// Package for the JSON validate/pretty-print block: payload types, constants,
// scalar automaton function. No dependencies.
package jvpp_pkg;

   localparam int MAX_DEPTH = 16;
   localparam int DEPTH_W   = 5;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       is_status;
      logic       status_error;
      logic       last_in_run;
   } rsp_type;

   // classified job from front to back
   typedef struct packed {
      logic              indent;     // newline plus 2*spaces first
      logic [DEPTH_W-1:0] spaces;    // indentation level
      logic [7:0]        ch;         // main character (if emit_ch)
      logic              emit_ch;
      logic              colon_sp;   // extra space after colon
      logic              status;     // status word at end
      logic              status_err;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_NL, BK_SP, BK_CH, BK_CSP, BK_ST
   } back_state_type;

   localparam logic [4:0] SC_EMPTY   = 5'd0;
   localparam logic [4:0] SC_TRUE    = 5'd4;
   localparam logic [4:0] SC_FALSE   = 5'd9;
   localparam logic [4:0] SC_NULL    = 5'd13;
   localparam logic [4:0] SC_MINUS   = 5'd14;
   localparam logic [4:0] SC_INT     = 5'd15;
   localparam logic [4:0] SC_DOT     = 5'd16;
   localparam logic [4:0] SC_FRAC    = 5'd17;
   localparam logic [4:0] SC_EXP     = 5'd18;
   localparam logic [4:0] SC_EXPSIGN = 5'd19;
   localparam logic [4:0] SC_EXPDIG  = 5'd20;
   localparam logic [4:0] SC_BAD     = 5'd21;

   function automatic logic [4:0] scalar_next(input logic [4:0] s, input logic [7:0] c);
      logic d;
      logic [4:0] n;
      d = (c >= "0") && (c <= "9");
      n = SC_BAD;
      case (s)
         SC_EMPTY: begin
            if (c == "t") n = 5'd1;
            else if (c == "f") n = 5'd5;
            else if (c == "n") n = 5'd10;
            else if (c == "-") n = SC_MINUS;
            else if (d) n = SC_INT;
         end
         5'd1: if (c == "r") n = 5'd2;
         5'd2: if (c == "u") n = 5'd3;
         5'd3: if (c == "e") n = SC_TRUE;
         5'd5: if (c == "a") n = 5'd6;
         5'd6: if (c == "l") n = 5'd7;
         5'd7: if (c == "s") n = 5'd8;
         5'd8: if (c == "e") n = SC_FALSE;
         5'd10: if (c == "u") n = 5'd11;
         5'd11: if (c == "l") n = 5'd12;
         5'd12: if (c == "l") n = SC_NULL;
         SC_MINUS: if (d) n = SC_INT;
         SC_INT: begin
            if (d) n = SC_INT;
            else if (c == ".") n = SC_DOT;
            else if (c == "e" || c == "E") n = SC_EXP;
         end
         SC_DOT: if (d) n = SC_FRAC;
         SC_FRAC: begin
            if (d) n = SC_FRAC;
            else if (c == "e" || c == "E") n = SC_EXP;
         end
         SC_EXP: begin
            if (c == "+" || c == "-") n = SC_EXPSIGN;
            else if (d) n = SC_EXPDIG;
         end
         SC_EXPSIGN, SC_EXPDIG: if (d) n = SC_EXPDIG;
         default: n = SC_BAD;
      endcase
      return n;
   endfunction

   function automatic logic scalar_ok(input logic [4:0] s);
      return s == SC_EMPTY || s == SC_TRUE || s == SC_FALSE || s == SC_NULL ||
             s == SC_INT || s == SC_FRAC || s == SC_EXPDIG;
   endfunction

endpackage

[rtl/json_validate_pretty_print.sv]
// Streaming JSON validator and two-space pretty printer. The front end parses
// one byte per cycle while the two-entry job queue has room; whitespace
// outside strings makes no job unless it is the last byte. The back end takes
// a job from the queue, emits its output words one by one and takes the next
// job only after the last of them (an open-bracket indent at depth d takes
// 2d+2 words); a stalled result port stops it. A status word follows the last
// byte. Uses jvpp_pkg, jvpp_front, jvpp_queue, jvpp_back.
module json_validate_pretty_print import jvpp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;

   jvpp_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   jvpp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
   );

   jvpp_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

[rtl/jvpp_front.sv]
// Front end: parses each byte, keeps syntax state, bracket stack, and
// pushes one job per byte that has output. Uses jvpp_pkg.
module jvpp_front import jvpp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job
);

   logic in_string_ff, in_string_in;
   logic after_escape_ff, after_escape_in;
   logic need_newline_ff, need_newline_in;
   logic after_comma_ff, after_comma_in;
   logic seen_any_ff, seen_any_in;
   logic error_seen_ff, error_seen_in;
   logic [DEPTH_W-1:0] nest_depth_ff, nest_depth_in;
   logic [4:0] scalar_state_ff, scalar_state_in;
   logic [MAX_DEPTH-1:0] stack_ff, stack_in;

   logic [7:0] c;
   logic is_sp, err, sc_ok;
   logic [DEPTH_W:0] depth_p1;
   logic [DEPTH_W-1:0] top_idx;

   assign req_ready = job_ready;
   assign c = req_data.ch;
   assign is_sp = (c == " ") || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b) ||
                  (c == 8'h0c) || (c == 8'h0d);
   assign sc_ok = scalar_ok(scalar_state_ff);
   assign depth_p1 = {1'b0, nest_depth_ff} + 1'b1;
   assign top_idx = nest_depth_ff - 1'b1;

   always_comb begin
      in_string_in    = in_string_ff;
      after_escape_in = after_escape_ff;
      need_newline_in = need_newline_ff;
      after_comma_in  = after_comma_ff;
      seen_any_in     = seen_any_ff;
      nest_depth_in   = nest_depth_ff;
      scalar_state_in = scalar_state_ff;
      stack_in        = stack_ff;
      err             = 1'b0;
      job             = '0;
      job.ch          = c;
      job.spaces      = nest_depth_ff;
      if (!error_seen_ff) begin
         if (in_string_ff) begin
            job.emit_ch = 1'b1;
            if (after_escape_ff) after_escape_in = 1'b0;
            else if (c == 8'h5c) after_escape_in = 1'b1;
            else if (c == "\"") in_string_in = 1'b0;
         end else if (!is_sp) begin
            seen_any_in = 1'b1;
            after_comma_in = 1'b0;
            if (c == "\"" || c == "{" || c == "[" || c == "}" || c == "]" ||
                c == "," || c == ":") scalar_state_in = SC_EMPTY;
            if (c == "\"") begin
               if (!sc_ok) err = 1'b1;
               else begin
                  job.indent = need_newline_ff;
                  need_newline_in = 1'b0;
                  in_string_in = 1'b1;
                  job.emit_ch = 1'b1;
               end
            end else if (c == "{" || c == "[") begin
               if (!sc_ok || depth_p1 >= (DEPTH_W+1)'(MAX_DEPTH)) err = 1'b1;
               else begin
                  job.indent = need_newline_ff;
                  stack_in[nest_depth_ff[$clog2(MAX_DEPTH)-1:0]] = (c == "{");
                  nest_depth_in = depth_p1[DEPTH_W-1:0];
                  job.emit_ch = 1'b1;
                  need_newline_in = 1'b1;
               end
            end else if (c == "}" || c == "]") begin
               if (!sc_ok || after_comma_ff || nest_depth_ff == '0 ||
                   stack_ff[top_idx[$clog2(MAX_DEPTH)-1:0]] != (c == "}"))
                  err = 1'b1;
               else begin
                  nest_depth_in = top_idx;
                  job.indent = !need_newline_ff;
                  job.spaces = top_idx;
                  job.emit_ch = 1'b1;
                  need_newline_in = 1'b0;
               end
            end else if (c == ",") begin
               if (!sc_ok || nest_depth_ff == '0 || need_newline_ff) err = 1'b1;
               else begin
                  job.emit_ch = 1'b1;
                  need_newline_in = 1'b1;
                  after_comma_in = 1'b1;
               end
            end else if (c == ":") begin
               if (!sc_ok || nest_depth_ff == '0) err = 1'b1;
               else begin
                  job.emit_ch = 1'b1;
                  job.colon_sp = 1'b1;
                  need_newline_in = 1'b0;
               end
            end else begin
               job.indent = need_newline_ff;
               need_newline_in = 1'b0;
               job.emit_ch = 1'b1;
               scalar_state_in = scalar_next(scalar_state_ff, c);
            end
         end
      end
      error_seen_in = error_seen_ff | err;
      if (req_data.last) begin
         job.status = 1'b1;
         job.status_err = error_seen_in || in_string_in || nest_depth_in != '0 ||
                          !seen_any_in || !scalar_ok(scalar_state_in);
      end
      // suppress outputs on error
      if (error_seen_in) begin
         job.indent = 1'b0;
         job.emit_ch = 1'b0;
         job.colon_sp = 1'b0;
      end
   end

   assign job_valid = req_valid && (job.indent || job.emit_ch || job.status);

   always_ff @(posedge clock) begin
      if (reset || (req_valid && req_ready && req_data.last)) begin
         in_string_ff    <= 1'b0;
         after_escape_ff <= 1'b0;
         need_newline_ff <= 1'b0;
         after_comma_ff  <= 1'b0;
         seen_any_ff     <= 1'b0;
         error_seen_ff   <= 1'b0;
         nest_depth_ff   <= '0;
         scalar_state_ff <= SC_EMPTY;
      end else if (req_valid && req_ready) begin
         in_string_ff    <= in_string_in;
         after_escape_ff <= after_escape_in;
         need_newline_ff <= need_newline_in;
         after_comma_ff  <= after_comma_in;
         seen_any_ff     <= seen_any_in;
         error_seen_ff   <= error_seen_in;
         nest_depth_ff   <= nest_depth_in;
         scalar_state_ff <= scalar_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) stack_ff <= stack_in;
   end

endmodule

[rtl/jvpp_queue.sv]
// Two-entry job queue between front and back. Uses jvpp_pkg.
module jvpp_queue import jvpp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   job_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_job   = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_job;
   end

endmodule

[rtl/jvpp_back.sv]
// Back end: expands one job into output words (indent run, char, space,
// status) through an output register. Uses jvpp_pkg.
module jvpp_back import jvpp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   back_state_type state_ff, state_in;
   logic [DEPTH_W:0] cnt_ff, cnt_in;
   logic out_free;
   logic emit;
   rsp_type word;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   // next step after the current one
   function automatic back_state_type after_step(input back_state_type s,
                                                 input job_type j);
      back_state_type n;
      n = BK_IDLE;
      if ((s == BK_NL || s == BK_SP) && j.emit_ch) n = BK_CH;
      else if ((s == BK_NL || s == BK_SP || s == BK_CH) && j.colon_sp) n = BK_CSP;
      else if (s != BK_ST && j.status) n = BK_ST;
      return n;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      emit      = 1'b0;
      job_ready = 1'b0;
      word      = '0;
      if (state_ff == BK_IDLE) begin
         if (job_valid) begin
            if (job.indent) state_in = BK_NL;
            else if (job.emit_ch) state_in = BK_CH;
            else state_in = BK_ST;
            cnt_in = {job.spaces, 1'b0};
         end
      end else if (out_free) begin
         emit = 1'b1;
         case (state_ff)
            BK_NL: begin
               word.out_char = 8'h0a;
               state_in = (cnt_ff != '0) ? BK_SP : after_step(BK_NL, job);
            end
            BK_SP: begin
               word.out_char = " ";
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == (DEPTH_W+1)'(1)) state_in = after_step(BK_SP, job);
            end
            BK_CH: begin
               word.out_char = job.ch;
               state_in = after_step(BK_CH, job);
            end
            BK_CSP: begin
               word.out_char = " ";
               state_in = after_step(BK_CSP, job);
            end
            BK_ST: begin
               word.is_status = 1'b1;
               word.status_error = job.status_err;
               state_in = BK_IDLE;
            end
            default: state_in = BK_IDLE;
         endcase
         word.last_in_run = (state_in == BK_IDLE);
         job_ready = (state_in == BK_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) rsp_ff <= word;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
